@@ design/esiq_pkg.sv @@
// ----------------------------------------------------------------------------
// esiq_pkg
// Shared widths, codes and types of the encoder and switch input qualifier.
// ----------------------------------------------------------------------------
package esiq_pkg;

  localparam int COUNT_WIDTH     = 16;
  localparam int VALUE_WIDTH     = 16;
  localparam int FIELD_WIDTH     = 16;
  localparam int OUT_COUNT_WIDTH = 16;
  localparam int STEP_WIDTH      = 8;
  localparam int HOLD_WIDTH      = 10;
  localparam int ELAPSED_WIDTH   = 11;
  localparam int APB_ADDR_WIDTH  = 4;
  localparam int APB_DATA_WIDTH  = 32;

  localparam int PROD_WIDTH = COUNT_WIDTH + STEP_WIDTH + 1;
  localparam int SUM_WIDTH  = ((PROD_WIDTH > VALUE_WIDTH + 1) ? PROD_WIDTH : VALUE_WIDTH + 1) + 1;

  localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic [ELAPSED_WIDTH-1:0]      ELAPSED_MAX = '1;

  localparam logic [HOLD_WIDTH-1:0] ENC_HOLDOFF_RST = HOLD_WIDTH'(2);
  localparam logic [HOLD_WIDTH-1:0] BUTTON_HOLD_RST = HOLD_WIDTH'(2);
  localparam logic [HOLD_WIDTH-1:0] IDLE_HOLD_RST   = HOLD_WIDTH'(200);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TAKE   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_ENC_HOLDOFF = 2'd0,
    REG_BUTTON_HOLD = 2'd1,
    REG_IDLE_HOLD   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [HOLD_WIDTH-1:0] enc_holdoff;
    logic [HOLD_WIDTH-1:0] button_hold;
    logic [HOLD_WIDTH-1:0] idle_hold;
  } cfg_t;

  // Per-cycle control toward the state-holding units
  typedef struct packed {
    logic sample;
    logic take;
    logic primed;
  } tick_ctrl_t;

  typedef struct packed {
    op_t                    operation;
    logic                   pin_a;
    logic                   pin_b;
    logic                   push_pin_n;
    logic                   idle_pin_n;
    logic [FIELD_WIDTH-1:0] start_value;
    logic [FIELD_WIDTH-1:0] lower_limit;
    logic [FIELD_WIDTH-1:0] upper_limit;
    logic [STEP_WIDTH-1:0]  step_size;
  } in_item_t;

endpackage

@@ design/esiq_in_if.sv @@
// ----------------------------------------------------------------------------
// esiq_in_if
// Input item channel: valid/ready handshake with sample or take payload.
// ----------------------------------------------------------------------------
interface esiq_in_if;
  import esiq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic                   pin_a;
  logic                   pin_b;
  logic                   push_pin_n;
  logic                   idle_pin_n;
  logic [FIELD_WIDTH-1:0] start_value;
  logic [FIELD_WIDTH-1:0] lower_limit;
  logic [FIELD_WIDTH-1:0] upper_limit;
  logic [STEP_WIDTH-1:0]  step_size;

  modport source (
    output valid, operation, pin_a, pin_b, push_pin_n, idle_pin_n,
           start_value, lower_limit, upper_limit, step_size,
    input  ready
  );

  modport sink (
    input  valid, operation, pin_a, pin_b, push_pin_n, idle_pin_n,
           start_value, lower_limit, upper_limit, step_size,
    output ready
  );

endinterface

@@ design/esiq_out_if.sv @@
// ----------------------------------------------------------------------------
// esiq_out_if
// Result item channel: valid/ready handshake with qualified states and count.
// ----------------------------------------------------------------------------
interface esiq_out_if;
  import esiq_pkg::*;

  logic                              valid;
  logic                              ready;
  logic                              push_pressed;
  logic                              idle_active;
  logic signed [OUT_COUNT_WIDTH-1:0] step_count;
  logic                              has_steps;
  logic        [FIELD_WIDTH-1:0]     bounded_value;

  modport source (
    output valid, push_pressed, idle_active, step_count, has_steps, bounded_value,
    input  ready
  );

  modport sink (
    input  valid, push_pressed, idle_active, step_count, has_steps, bounded_value,
    output ready
  );

endinterface

@@ design/esiq_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// esiq_cfg_regs
// APB register bank: encoder hold-off and the two switch hold times.
// ----------------------------------------------------------------------------
module esiq_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [esiq_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [esiq_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [esiq_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                pready,
  output esiq_pkg::cfg_t                      cfg
);
  import esiq_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_WIDTH-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ENC_HOLDOFF: cfg_nxt.enc_holdoff = pwdata[HOLD_WIDTH-1:0];
        REG_BUTTON_HOLD: cfg_nxt.button_hold = pwdata[HOLD_WIDTH-1:0];
        REG_IDLE_HOLD:   cfg_nxt.idle_hold   = pwdata[HOLD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enc_holdoff <= ENC_HOLDOFF_RST;
      cfg_r.button_hold <= BUTTON_HOLD_RST;
      cfg_r.idle_hold   <= IDLE_HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENC_HOLDOFF: prdata = APB_DATA_WIDTH'(cfg_r.enc_holdoff);
      REG_BUTTON_HOLD: prdata = APB_DATA_WIDTH'(cfg_r.button_hold);
      REG_IDLE_HOLD:   prdata = APB_DATA_WIDTH'(cfg_r.idle_hold);
      default:         prdata = '0;
    endcase
  end

endmodule

@@ design/esiq_debounce.sv @@
// ----------------------------------------------------------------------------
// esiq_debounce
// One switch qualifier: raw level, hold counter and qualified state.
// ----------------------------------------------------------------------------
module esiq_debounce (
  input  logic                            clk,
  input  logic                            rst_n,
  input  esiq_pkg::tick_ctrl_t            ctrl,
  input  logic                            pin_n,
  input  logic [esiq_pkg::HOLD_WIDTH-1:0] hold,
  output logic                            stable
);
  import esiq_pkg::*;

  logic                     raw_r;
  logic                     raw_nxt;
  logic                     stable_r;
  logic                     stable_nxt;
  logic [ELAPSED_WIDTH-1:0] elapsed_r;
  logic [ELAPSED_WIDTH-1:0] elapsed_nxt;
  logic [ELAPSED_WIDTH-1:0] elapsed_inc;
  logic                     level_now;

  assign level_now   = ~pin_n;
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;

  always_comb begin
    raw_nxt     = raw_r;
    elapsed_nxt = elapsed_inc;
    if (!ctrl.primed) begin
      raw_nxt = level_now;
    end else if (raw_r != level_now) begin
      // restart the hold window on every raw change
      raw_nxt     = level_now;
      elapsed_nxt = '0;
    end
    stable_nxt = (elapsed_nxt > ELAPSED_WIDTH'(hold)) ? raw_nxt : stable_r;
  end

  // take items leave the switch state alone
  assign stable = ctrl.sample ? stable_nxt : stable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r     <= 1'b0;
      stable_r  <= 1'b0;
      elapsed_r <= ELAPSED_MAX;
    end else if (ctrl.sample) begin
      raw_r     <= raw_nxt;
      stable_r  <= stable_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

@@ design/esiq_quad.sv @@
// ----------------------------------------------------------------------------
// esiq_quad
// Quadrature step counter: A-phase edge detect, hold-off and saturating count.
// ----------------------------------------------------------------------------
module esiq_quad (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  esiq_pkg::tick_ctrl_t                    ctrl,
  input  logic                                    pin_a,
  input  logic                                    pin_b,
  input  logic [esiq_pkg::HOLD_WIDTH-1:0]         holdoff,
  output logic signed [esiq_pkg::COUNT_WIDTH-1:0] count_cur,
  output logic signed [esiq_pkg::COUNT_WIDTH-1:0] count_rpt
);
  import esiq_pkg::*;

  logic                          phase_r;
  logic                          phase_nxt;
  logic signed [COUNT_WIDTH-1:0] count_r;
  logic signed [COUNT_WIDTH-1:0] count_nxt;
  logic [ELAPSED_WIDTH-1:0]      elapsed_r;
  logic [ELAPSED_WIDTH-1:0]      elapsed_nxt;
  logic [ELAPSED_WIDTH-1:0]      elapsed_inc;

  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_inc;
    if (!ctrl.primed) begin
      phase_nxt = pin_a;
    end else if (pin_a != phase_r) begin
      phase_nxt = pin_a;
      if (elapsed_inc > ELAPSED_WIDTH'(holdoff)) begin
        // direction: new phase differing from B counts up
        if (pin_a != pin_b) begin
          if (count_r != COUNT_MAX) begin
            count_nxt = count_r + 1'b1;
          end
        end else if (count_r != COUNT_MIN) begin
          count_nxt = count_r - 1'b1;
        end
        elapsed_nxt = '0;
      end
    end
  end

  assign count_cur = count_r;
  assign count_rpt = ctrl.take ? count_r : count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 1'b0;
      count_r   <= '0;
      elapsed_r <= ELAPSED_MAX;
    end else if (ctrl.sample) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
    end else if (ctrl.take) begin
      count_r <= '0;
    end
  end

endmodule

@@ design/esiq_bound.sv @@
// ----------------------------------------------------------------------------
// esiq_bound
// Bounded add: start plus count times step, clamped in the direction of travel.
// ----------------------------------------------------------------------------
module esiq_bound (
  input  logic signed [esiq_pkg::COUNT_WIDTH-1:0] count,
  input  logic        [esiq_pkg::STEP_WIDTH-1:0]  step_size,
  input  logic        [esiq_pkg::FIELD_WIDTH-1:0] start_value,
  input  logic        [esiq_pkg::FIELD_WIDTH-1:0] lower_limit,
  input  logic        [esiq_pkg::FIELD_WIDTH-1:0] upper_limit,
  output logic        [esiq_pkg::FIELD_WIDTH-1:0] bounded_value
);
  import esiq_pkg::*;

  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [SUM_WIDTH-1:0]  start_s;
  logic signed [SUM_WIDTH-1:0]  lower_s;
  logic signed [SUM_WIDTH-1:0]  upper_s;
  logic signed [SUM_WIDTH-1:0]  sum;
  logic signed [SUM_WIDTH-1:0]  result;
  logic [VALUE_WIDTH-1:0]       start_v;
  logic [VALUE_WIDTH-1:0]       lower_v;
  logic [VALUE_WIDTH-1:0]       upper_v;

  assign start_v = VALUE_WIDTH'(start_value);
  assign lower_v = VALUE_WIDTH'(lower_limit);
  assign upper_v = VALUE_WIDTH'(upper_limit);

  assign start_s = SUM_WIDTH'({1'b0, start_v});
  assign lower_s = SUM_WIDTH'({1'b0, lower_v});
  assign upper_s = SUM_WIDTH'({1'b0, upper_v});

  assign prod = PROD_WIDTH'(count) * PROD_WIDTH'($signed({1'b0, step_size}));
  assign sum  = start_s + SUM_WIDTH'(prod);

  always_comb begin
    priority if (prod > 0 && sum > upper_s) begin
      result = upper_s;
    end else if (prod < 0 && sum < lower_s) begin
      result = lower_s;
    end else begin
      result = sum;
    end
  end

  assign bounded_value = FIELD_WIDTH'(result[VALUE_WIDTH-1:0]);

endmodule

@@ design/encoder_switch_input_qualifier.sv @@
// ----------------------------------------------------------------------------
// encoder_switch_input_qualifier
// Quadrature encoder counter with hold-off and two debounced switch inputs.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, sustained, unless the output
// stalls with both registers full. An accepted item is held in an input
// register, where the encoder, switch and bounded-add logic evaluate it
// against the current state and update that state as the item advances;
// its result is then loaded into the output register and offered there.
// A stalled output holds the result and the input register, and the input
// side stalls only when both are full. Sample items advance time by one
// tick; take items read and clear the count without advancing time.
// ----------------------------------------------------------------------------
module encoder_switch_input_qualifier (
  input  logic                                clk,
  input  logic                                rst_n,
  esiq_in_if.sink                             in_if,
  esiq_out_if.source                          out_if,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [esiq_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [esiq_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [esiq_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                pready
);
  import esiq_pkg::*;

  cfg_t       cfg;
  tick_ctrl_t ctrl;

  logic     in_fire;
  logic     out_open;
  logic     adv;

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_item_t s1_item_r;
  in_item_t in_item;

  logic     primed_r;
  logic     primed_nxt;

  logic                          push_stable;
  logic                          idle_stable;
  logic signed [COUNT_WIDTH-1:0] count_cur;
  logic signed [COUNT_WIDTH-1:0] count_rpt;
  logic [FIELD_WIDTH-1:0]        bound_val;

  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic                              out_push_r;
  logic                              out_idle_r;
  logic signed [OUT_COUNT_WIDTH-1:0] out_count_r;
  logic                              out_has_r;
  logic [FIELD_WIDTH-1:0]            out_bound_r;

  // handshake
  assign out_open    = !out_valid_r || out_if.ready;
  assign adv         = s1_valid_r && out_open;
  assign in_if.ready = !s1_valid_r || out_open;
  assign in_fire     = in_if.valid && in_if.ready;

  always_comb begin
    in_item.operation   = op_t'(in_if.operation);
    in_item.pin_a       = in_if.pin_a;
    in_item.pin_b       = in_if.pin_b;
    in_item.push_pin_n  = in_if.push_pin_n;
    in_item.idle_pin_n  = in_if.idle_pin_n;
    in_item.start_value = in_if.start_value;
    in_item.lower_limit = in_if.lower_limit;
    in_item.upper_limit = in_if.upper_limit;
    in_item.step_size   = in_if.step_size;
  end

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_if.ready);

  assign ctrl.sample = adv && (s1_item_r.operation == OP_SAMPLE);
  assign ctrl.take   = adv && (s1_item_r.operation == OP_TAKE);
  assign ctrl.primed = primed_r;

  assign primed_nxt = primed_r || ctrl.sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      primed_r    <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      primed_r    <= primed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
  end

  esiq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  esiq_quad u_quad (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .pin_a     (s1_item_r.pin_a),
    .pin_b     (s1_item_r.pin_b),
    .holdoff   (cfg.enc_holdoff),
    .count_cur (count_cur),
    .count_rpt (count_rpt)
  );

  esiq_debounce u_push (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .pin_n  (s1_item_r.push_pin_n),
    .hold   (cfg.button_hold),
    .stable (push_stable)
  );

  esiq_debounce u_idle (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .pin_n  (s1_item_r.idle_pin_n),
    .hold   (cfg.idle_hold),
    .stable (idle_stable)
  );

  esiq_bound u_bound (
    .count         (count_cur),
    .step_size     (s1_item_r.step_size),
    .start_value   (s1_item_r.start_value),
    .lower_limit   (s1_item_r.lower_limit),
    .upper_limit   (s1_item_r.upper_limit),
    .bounded_value (bound_val)
  );

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_push_r  <= push_stable;
      out_idle_r  <= idle_stable;
      out_count_r <= OUT_COUNT_WIDTH'(count_rpt);
      out_has_r   <= (count_rpt != '0);
      out_bound_r <= ctrl.take ? bound_val : '0;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.push_pressed  = out_push_r;
  assign out_if.idle_active   = out_idle_r;
  assign out_if.step_count    = out_count_r;
  assign out_if.has_steps     = out_has_r;
  assign out_if.bounded_value = out_bound_r;

`ifndef SYNTHESIS
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.take |=> (count_cur == '0))
    else $error("count not cleared after take item");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (s1_valid_r && out_valid_r && !out_if.ready))
    else $error("input stalled while a stage was free");

  a_primed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |=> primed_r)
    else $error("primed flag dropped");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced item produced no result");
`endif

endmodule
